@@ design/rtv_pkg.sv @@
// rtv_pkg: shared types and constants for the resource table validator
// no dependencies
`default_nettype none

package rtv_pkg;

  localparam int unsigned ENTRY_BYTES = 22;
  localparam int unsigned NAME_FIELD  = 12;
  localparam int unsigned MIN_SPAN    = 46;
  localparam int unsigned COUNT_MIN   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [4:0] POS_LAST        = 5'(ENTRY_BYTES - 1);
  localparam logic [4:0] POS_NAME_LAST   = 5'(NAME_FIELD);
  localparam logic [4:0] POS_OFFSET_BASE = 5'(NAME_FIELD + 1);
  localparam logic [4:0] POS_OFFSET_LAST = 5'(NAME_FIELD + 4);
  localparam logic [4:0] POS_SIZE_BASE   = 5'(NAME_FIELD + 5);
  localparam logic [4:0] POS_SIZE_LAST   = 5'(NAME_FIELD + 8);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_TABLE,
    PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    FR_HDR0,
    FR_HDR1,
    FR_ENTRY
  } front_state_t;

  typedef enum logic [1:0] {
    KIND_HDR0,
    KIND_HDR1,
    KIND_ENTRY
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_SHORT     = 4'd1,
    ERR_COUNT     = 4'd2,
    ERR_TABLE     = 4'd3,
    ERR_NAME_LEN  = 4'd4,
    ERR_PADDING   = 4'd5,
    ERR_OFFSET    = 4'd6,
    ERR_SIZE      = 4'd7,
    ERR_TRAILING  = 4'd8
  } err_t;

  typedef struct packed {
    logic       restart;
    kind_t      kind;
    logic [4:0] pos;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [15:0] member_index;
    logic [31:0] payload_offset;
    logic [31:0] payload_size;
    logic [3:0]  name_length;
    logic [7:0]  resource_type;
    logic        is_final;
    err_t        error_code;
  } result_t;

endpackage

`default_nettype wire

@@ design/rtv_byte_if.sv @@
// rtv_byte_if: input byte channel, valid/ready with byte payload
// no dependencies
`default_nettype none

interface rtv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       first_byte;

  modport source(output valid, byte_value, first_byte, input ready);
  modport sink(input valid, byte_value, first_byte, output ready);
endinterface

`default_nettype wire

@@ design/rtv_result_if.sv @@
// rtv_result_if: result channel, valid/ready with member record payload
// no dependencies
`default_nettype none

interface rtv_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] member_index;
  logic [31:0] payload_offset;
  logic [31:0] payload_size;
  logic [3:0]  name_length;
  logic [7:0]  resource_type;
  logic        is_final;
  logic [3:0]  error_code;

  modport source(output valid, member_index, payload_offset, payload_size, name_length,
                 resource_type, is_final, error_code, input ready);
  modport sink(input valid, member_index, payload_offset, payload_size, name_length,
               resource_type, is_final, error_code, output ready);
endinterface

`default_nettype wire

@@ design/resource_table_validator.sv @@
// resource_table_validator: top level, span register, front, queue and back
// one byte per cycle while the result side takes results; a result's byte is held in a queue slot,
// then the result is loaded into the output register as the slot pops; pops wait while the result side stalls
// depends on rtv_pkg, rtv_byte_if, rtv_result_if, rtv_front, rtv_queue, rtv_back
// synchronous reset puts the parser in the header phase and clears the span to zero
`default_nettype none

module resource_table_validator #(
  parameter int unsigned QUEUE_DEPTH = rtv_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  rtv_byte_if.sink         item,
  rtv_result_if.source     result,
  input  wire logic        cfg_wen,
  input  wire logic [31:0] cfg_wdata
);

  logic [31:0]    file_span;
  logic           room;
  logic           push;
  logic           pop;
  logic           head_valid;
  rtv_pkg::item_t classified;
  rtv_pkg::item_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_span <= '0;
    end else if (cfg_wen) begin
      file_span <= cfg_wdata;
    end
  end

  rtv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .room       (room),
    .push       (push),
    .classified (classified)
  );

  rtv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (classified),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .room       (room)
  );

  rtv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .file_span  (file_span),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule

`default_nettype wire

@@ design/rtv_front.sv @@
// rtv_front: accepts input beats and tags each with its place in the archive
// depends on rtv_pkg, rtv_byte_if
`default_nettype none

module rtv_front (
  input  wire logic           clk,
  input  wire logic           rst,
  rtv_byte_if.sink            item,
  input  wire logic           room,
  output logic                push,
  output rtv_pkg::item_t      classified
);

  rtv_pkg::front_state_t state;
  rtv_pkg::front_state_t state_next;
  logic [4:0]            pos;
  logic [4:0]            pos_next;

  assign item.ready = room;
  assign push       = item.valid & room;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtv_pkg::FR_HDR0;
      pos   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

  always_comb begin
    classified.restart = item.first_byte;
    classified.value   = item.byte_value;
    classified.pos     = '0;
    classified.kind    = rtv_pkg::KIND_HDR0;
    if (!item.first_byte) begin
      case (state)
        rtv_pkg::FR_HDR0: classified.kind = rtv_pkg::KIND_HDR0;
        rtv_pkg::FR_HDR1: classified.kind = rtv_pkg::KIND_HDR1;
        rtv_pkg::FR_ENTRY: begin
          classified.kind = rtv_pkg::KIND_ENTRY;
          classified.pos  = pos;
        end
        default: classified.kind = rtv_pkg::KIND_HDR0;
      endcase
    end

    state_next = state;
    pos_next   = pos;
    if (push) begin
      case (classified.kind)
        rtv_pkg::KIND_HDR0: begin
          state_next = rtv_pkg::FR_HDR1;
          pos_next   = '0;
        end
        rtv_pkg::KIND_HDR1: begin
          state_next = rtv_pkg::FR_ENTRY;
          pos_next   = '0;
        end
        rtv_pkg::KIND_ENTRY: begin
          pos_next = (pos == rtv_pkg::POS_LAST) ? 5'd0 : pos + 5'd1;
        end
        default: state_next = rtv_pkg::FR_HDR0;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/rtv_queue.sv @@
// rtv_queue: short fifo of tagged beats between front and back
// depends on rtv_pkg
`default_nettype none

module rtv_queue #(
  parameter int unsigned DEPTH = rtv_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rtv_pkg::item_t  push_item,
  input  wire logic            pop,
  output logic                 head_valid,
  output rtv_pkg::item_t       head,
  output logic                 room
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rtv_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign room       = (fill != CNT_FULL);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/rtv_back.sv @@
// rtv_back: table parser and checker, drives the result output register
// depends on rtv_pkg, rtv_result_if
`default_nettype none

module rtv_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [31:0]    file_span,
  input  wire logic           head_valid,
  input  wire rtv_pkg::item_t head,
  output logic                pop,
  rtv_result_if.source        result
);

  rtv_pkg::phase_t  phase;
  rtv_pkg::phase_t  phase_next;
  logic [15:0]      member_count;
  logic [15:0]      member_count_next;
  logic [15:0]      entries_done;
  logic [15:0]      entries_done_next;
  logic [31:0]      payload_cursor;
  logic [31:0]      payload_cursor_next;
  logic [31:0]      offset_accum;
  logic [31:0]      offset_accum_next;
  logic [31:0]      size_accum;
  logic [31:0]      size_accum_next;
  logic [7:0]       name_len_held;
  logic [7:0]       name_len_held_next;
  logic             padding_bad;
  logic             padding_bad_next;

  logic             out_valid;
  rtv_pkg::result_t out_data;
  logic             fire;
  rtv_pkg::result_t res;

  logic [15:0]      hdr_count;
  logic [20:0]      tbl_bytes;
  logic [32:0]      entry_end;
  logic [1:0]       off_lane;
  logic [1:0]       size_lane;
  logic [4:0]       name_idx;
  logic [16:0]      done_plus;

  assign pop        = head_valid & (~out_valid | result.ready);
  assign hdr_count  = {head.value, member_count[7:0]};
  assign tbl_bytes  = 21'(hdr_count) * 21'(rtv_pkg::ENTRY_BYTES);
  assign entry_end  = {1'b0, size_accum} + {1'b0, payload_cursor};
  assign off_lane   = 2'(head.pos - rtv_pkg::POS_OFFSET_BASE);
  assign size_lane  = 2'(head.pos - rtv_pkg::POS_SIZE_BASE);
  assign name_idx   = head.pos - 5'd1;
  assign done_plus  = {1'b0, entries_done} + 17'd1;

  always_comb begin
    phase_next          = phase;
    member_count_next   = member_count;
    entries_done_next   = entries_done;
    payload_cursor_next = payload_cursor;
    offset_accum_next   = offset_accum;
    size_accum_next     = size_accum;
    name_len_held_next  = name_len_held;
    padding_bad_next    = padding_bad;
    fire                = 1'b0;
    res                 = '0;

    if (pop) begin
      if (head.restart) begin
        phase_next          = rtv_pkg::PH_HEADER;
        member_count_next   = '0;
        entries_done_next   = '0;
        payload_cursor_next = '0;
        offset_accum_next   = '0;
        size_accum_next     = '0;
        name_len_held_next  = '0;
        padding_bad_next    = 1'b0;
      end

      case (phase_next)
        rtv_pkg::PH_HEADER: begin
          if (head.kind == rtv_pkg::KIND_HDR0) begin
            if (file_span < 32'(rtv_pkg::MIN_SPAN)) begin
              fire           = 1'b1;
              res.is_final   = 1'b1;
              res.error_code = rtv_pkg::ERR_SHORT;
              phase_next     = rtv_pkg::PH_IDLE;
            end else begin
              member_count_next = {8'h00, head.value};
            end
          end else if (head.kind == rtv_pkg::KIND_HDR1) begin
            member_count_next = hdr_count;
            if (hdr_count < 16'(rtv_pkg::COUNT_MIN)) begin
              fire           = 1'b1;
              res.is_final   = 1'b1;
              res.error_code = rtv_pkg::ERR_COUNT;
              phase_next     = rtv_pkg::PH_IDLE;
            end else if (33'(tbl_bytes) > ({1'b0, file_span} - 33'd2)) begin
              fire           = 1'b1;
              res.is_final   = 1'b1;
              res.error_code = rtv_pkg::ERR_TABLE;
              phase_next     = rtv_pkg::PH_IDLE;
            end else begin
              payload_cursor_next = 32'(tbl_bytes) + 32'd2;
              phase_next          = rtv_pkg::PH_TABLE;
              entries_done_next   = '0;
            end
          end
        end
        rtv_pkg::PH_TABLE: begin
          if (head.kind == rtv_pkg::KIND_ENTRY) begin
            if (head.pos == 5'd0) begin
              name_len_held_next = head.value;
              padding_bad_next   = 1'b0;
              offset_accum_next  = '0;
              size_accum_next    = '0;
            end else if (head.pos <= rtv_pkg::POS_NAME_LAST) begin
              if (({3'b000, name_idx} >= name_len_held) && (head.value != 8'h00)) begin
                padding_bad_next = 1'b1;
              end
            end else if (head.pos <= rtv_pkg::POS_OFFSET_LAST) begin
              offset_accum_next[{off_lane, 3'b000} +: 8] = head.value;
            end else if (head.pos <= rtv_pkg::POS_SIZE_LAST) begin
              size_accum_next[{size_lane, 3'b000} +: 8] = head.value;
            end

            if (head.pos == rtv_pkg::POS_LAST) begin
              fire             = 1'b1;
              res.member_index = entries_done;
              if ((name_len_held < 8'd1) || (name_len_held > 8'(rtv_pkg::NAME_FIELD))) begin
                res.is_final   = 1'b1;
                res.error_code = rtv_pkg::ERR_NAME_LEN;
                phase_next     = rtv_pkg::PH_IDLE;
              end else if (padding_bad) begin
                res.is_final   = 1'b1;
                res.error_code = rtv_pkg::ERR_PADDING;
                phase_next     = rtv_pkg::PH_IDLE;
              end else if (offset_accum != payload_cursor) begin
                res.is_final   = 1'b1;
                res.error_code = rtv_pkg::ERR_OFFSET;
                phase_next     = rtv_pkg::PH_IDLE;
              end else if ((size_accum == '0) || (entry_end > {1'b0, file_span})) begin
                res.is_final   = 1'b1;
                res.error_code = rtv_pkg::ERR_SIZE;
                phase_next     = rtv_pkg::PH_IDLE;
              end else begin
                res.payload_offset  = offset_accum;
                res.payload_size    = size_accum;
                res.name_length     = name_len_held[3:0];
                res.resource_type   = head.value;
                payload_cursor_next = entry_end[31:0];
                entries_done_next   = done_plus[15:0];
                if (done_plus >= {1'b0, member_count}) begin
                  res.is_final   = 1'b1;
                  res.error_code = (entry_end[31:0] == file_span) ? rtv_pkg::ERR_NONE
                                                                  : rtv_pkg::ERR_TRAILING;
                  phase_next     = rtv_pkg::PH_IDLE;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= rtv_pkg::PH_HEADER;
      member_count   <= '0;
      entries_done   <= '0;
      payload_cursor <= '0;
      offset_accum   <= '0;
      size_accum     <= '0;
      name_len_held  <= '0;
      padding_bad    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      member_count   <= member_count_next;
      entries_done   <= entries_done_next;
      payload_cursor <= payload_cursor_next;
      offset_accum   <= offset_accum_next;
      size_accum     <= size_accum_next;
      name_len_held  <= name_len_held_next;
      padding_bad    <= padding_bad_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.member_index   = out_data.member_index;
  assign result.payload_offset = out_data.payload_offset;
  assign result.payload_size   = out_data.payload_size;
  assign result.name_length    = out_data.name_length;
  assign result.resource_type  = out_data.resource_type;
  assign result.is_final       = out_data.is_final;
  assign result.error_code     = out_data.error_code;

endmodule

`default_nettype wire
